// File: sv/oldq_pkg.sv
// ----------------------------------------------------------------------------
// oldq_pkg
// Shared types, codes and defaults of the ordered list deque with delete.
// ----------------------------------------------------------------------------
package oldq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic            latch_in;
    logic            push_front;
    logic            push_back;
    logic            pop_front;
    logic            dec_count;
    logic            clr_k;
    logic            inc_k;
    logic            rd_scan;
    logic            rd_shift;
    logic            wr_shift;
    logic            rd_first;
    logic            rd_last;
    logic            cap_first;
    logic            cap_last;
    logic            set_status;
    logic [ST_W-1:0] status_code;
    logic            load_out;
  } oldq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_empty;
    logic            is_full;
    logic            match;
    logic            k_last;
    logic            shift_more;
  } oldq_stat_t;

endpackage

// File: sv/ordered_list_deque_with_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_deque_with_delete
// Bounded ordered list of signed 32-bit values with push and pop at both ends
// and delete of the first matching value.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one result: status, front
// and back values (zero when empty) and entry count. Entries sit in a
// single-port-read, single-port-write circular store. Push and pop requests
// pass through decode, the front and back reads and the result load. Delete
// walks the store from the front, comparing one entry at a time, and then
// moves each later entry up one place; the entries compared and moved never
// exceed the count. A new request is accepted in the cycle after a result is
// loaded into the output register, even while that result is still waiting
// to be taken.
module ordered_list_deque_with_delete
  import oldq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_value
  input  logic [2:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // first_value, last_value, entry_count, zero pad
  output logic [1:0]  m_tuser    // status
);

  oldq_cmd_t              cmd;
  oldq_stat_t             stat;
  logic [ST_W-1:0]        out_status;
  logic [VAL_W-1:0]       out_first;
  logic [VAL_W-1:0]       out_last;
  logic [CNT_OUT_W-1:0]   out_count;

  oldq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oldq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_tuser),
    .in_value   (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_first  (out_first),
    .out_last   (out_last),
    .out_count  (out_count)
  );

  assign m_tdata = {3'b000, out_count, out_last, out_first};
  assign m_tuser = out_status;

  // one request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // full is reported only with a full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[68:64] == CNT_OUT_W'(CAPACITY)))
    else $error("full status with wrong count");

  // empty is reported only with an empty list and zero end values
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[68:0] == '0))
    else $error("empty status with non-zero result");

  // results never issue while the search or compaction is running
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out) |-> !(cmd.rd_scan || cmd.rd_shift || cmd.wr_shift))
    else $error("result loaded during list walk");

endmodule

// File: sv/oldq_dp.sv
// ----------------------------------------------------------------------------
// oldq_dp
// Datapath: circular entry store, front index, entry count, search index and
// the registered result.
// ----------------------------------------------------------------------------
module oldq_dp
  import oldq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [OP_W-1:0]       in_op,
  input  logic [VAL_W-1:0]      in_value,
  input  oldq_cmd_t             cmd,
  output oldq_stat_t            stat,
  output logic [ST_W-1:0]       out_status,
  output logic [VAL_W-1:0]      out_first,
  output logic [VAL_W-1:0]      out_last,
  output logic [CNT_OUT_W-1:0]  out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_S = (AW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] TOP_SLOT = AW'(CAPACITY - 1);

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [AW-1:0]    front;
  logic [CW-1:0]    count;
  logic [CW-1:0]    k;
  logic [OP_W-1:0]  op_reg;
  logic [VAL_W-1:0] val_reg;
  logic [ST_W-1:0]  status_reg;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] first_reg;
  logic [VAL_W-1:0] last_reg;

  logic [CW-1:0]    k_inc;
  logic [CW-1:0]    last_ofs;
  logic [AW-1:0]    front_dec;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // slot of the entry at a given offset from the base, wrapping round
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(ofs);
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[AW-1:0];
  endfunction

  assign k_inc     = k + CW'(1);
  assign last_ofs  = (count == '0) ? '0 : count - CW'(1);
  assign front_dec = (front == '0) ? TOP_SLOT : front - AW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot(front, k);
    wr_data = rd_data;
    if (cmd.push_front) begin
      wr_en   = 1'b1;
      wr_addr = front_dec;
      wr_data = val_reg;
    end else if (cmd.push_back) begin
      wr_en   = 1'b1;
      wr_addr = slot(front, count);
      wr_data = val_reg;
    end else if (cmd.wr_shift) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    rd_en   = cmd.rd_scan | cmd.rd_shift | cmd.rd_first | cmd.rd_last;
    rd_addr = front;
    if (cmd.rd_scan) begin
      rd_addr = slot(front, k);
    end else if (cmd.rd_shift) begin
      rd_addr = slot(front, k_inc);
    end else if (cmd.rd_last) begin
      rd_addr = slot(front, last_ofs);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      count      <= '0;
      k          <= '0;
      status_reg <= ST_OK;
    end else begin
      if (cmd.push_front) begin
        front <= front_dec;
      end else if (cmd.pop_front) begin
        front <= slot(front, CW'(1));
      end
      if (cmd.push_front || cmd.push_back) begin
        count <= count + CW'(1);
      end else if (cmd.pop_front || cmd.dec_count) begin
        count <= count - CW'(1);
      end
      if (cmd.clr_k) begin
        k <= '0;
      end else if (cmd.inc_k) begin
        k <= k_inc;
      end
      if (cmd.latch_in) begin
        status_reg <= ST_OK;
      end else if (cmd.set_status) begin
        status_reg <= cmd.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_reg  <= in_op;
      val_reg <= in_value;
    end
    if (cmd.cap_first) begin
      first_reg <= rd_data;
    end
    if (cmd.cap_last) begin
      last_reg <= rd_data;
    end
    if (cmd.load_out) begin
      out_status <= status_reg;
      out_first  <= (count == '0) ? '0 : first_reg;
      out_last   <= (count == '0) ? '0 : last_reg;
      out_count  <= CNT_OUT_W'(count);
    end
  end

  assign stat.op         = op_reg;
  assign stat.is_empty   = (count == '0);
  assign stat.is_full    = (count >= CAP_C);
  assign stat.match      = (rd_data == val_reg);
  assign stat.k_last     = ({1'b0, k} + (CW+1)'(1)) == {1'b0, count};
  assign stat.shift_more = ({1'b0, k} + (CW+1)'(2)) < {1'b0, count};

endmodule

// File: sv/oldq_ctrl.sv
// ----------------------------------------------------------------------------
// oldq_ctrl
// Controller: sequences each request through decode, search, compaction,
// end-value reads and result hand-off.
// ----------------------------------------------------------------------------
module oldq_ctrl
  import oldq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  oldq_stat_t stat,
  output oldq_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SHIFT_RD = 4'd4;
  localparam logic [3:0] S_SHIFT_WR = 4'd5;
  localparam logic [3:0] S_RD_FIRST = 4'd6;
  localparam logic [3:0] S_RD_LAST  = 4'd7;
  localparam logic [3:0] S_CAP_LAST = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RD_FIRST;
        case (stat.op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (stat.is_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else if (stat.op == OP_PUSH_FRONT) begin
              cmd.push_front = 1'b1;
            end else begin
              cmd.push_back = 1'b1;
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (stat.is_empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
            end else if (stat.op == OP_POP_FRONT) begin
              cmd.pop_front = 1'b1;
            end else begin
              cmd.dec_count = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat.is_empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
            end else begin
              cmd.clr_k  = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            state_next = S_RD_FIRST;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          if (stat.k_last) begin
            cmd.dec_count = 1'b1;
            state_next    = S_RD_FIRST;
          end else begin
            state_next = S_SHIFT_RD;
          end
        end else if (stat.k_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_next      = S_RD_FIRST;
        end else begin
          cmd.inc_k  = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_shift = 1'b1;
        state_next   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.inc_k    = 1'b1;
        if (stat.shift_more) begin
          state_next = S_SHIFT_RD;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        cmd.rd_first = 1'b1;
        state_next   = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.cap_first = 1'b1;
        cmd.rd_last   = 1'b1;
        state_next    = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd.cap_last = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: verif/ordered_list_deque_with_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_deque_with_delete_tb
// Self-checking bench for the bounded ordered list with delete by value.
// ----------------------------------------------------------------------------
// A queue-based copy of the list predicts status, front, back and count for
// every accepted request. A directed opening covers the empty, not-found and
// last-entry cases and the unused op codes. Random traffic then alternates
// between filling and draining runs so the full and empty limits are reached
// often. Values mostly come from a small pool so that deletes hit, and
// repeated values exercise the first-match rule. Four phases vary the idling
// on the request side and the stalling on the result side.
// ----------------------------------------------------------------------------
module ordered_list_deque_with_delete_tb;
  import oldq_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEF;
  localparam int REQS_PER_PHASE = 400;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int REPORT_MAX     = 10;
  localparam int POOL_SIZE      = 8;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [VAL_W-1:0]     first_value;
    logic [VAL_W-1:0]     last_value;
    logic [CNT_OUT_W-1:0] entry_count;
  } list_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // item_value
  logic [2:0]  s_tuser = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // first_value, last_value, entry_count, zero pad
  logic [1:0]  m_tuser;        // status

  logic [VAL_W-1:0] list_q[$];
  list_req_t        pending_q[$];
  list_view_t       view_q[$];
  logic [VAL_W-1:0] value_pool[POOL_SIZE];

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int unsigned cycles = 0;

  ordered_list_deque_with_delete #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // updates the list copy and returns what the block should report
  function automatic list_view_t apply_request(list_req_t req);
    list_view_t v;
    int         hit;
    v.status = ST_OK;
    hit = -1;
    case (req.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_q.size() >= CAPACITY) v.status = ST_FULL;
        else if (req.op == OP_PUSH_FRONT) list_q.push_front(req.value);
        else list_q.push_back(req.value);
      end
      OP_POP_FRONT: begin
        if (list_q.size() == 0) v.status = ST_EMPTY;
        else void'(list_q.pop_front());
      end
      OP_POP_BACK: begin
        if (list_q.size() == 0) v.status = ST_EMPTY;
        else void'(list_q.pop_back());
      end
      OP_DELETE: begin
        if (list_q.size() == 0) begin
          v.status = ST_EMPTY;
        end else begin
          foreach (list_q[i])
            if (hit < 0 && list_q[i] == req.value) hit = i;
          if (hit < 0) v.status = ST_NOT_FOUND;
          else list_q.delete(hit);
        end
      end
      default: ;
    endcase
    v.first_value = (list_q.size() != 0) ? list_q[0] : '0;
    v.last_value  = (list_q.size() != 0) ? list_q[list_q.size()-1] : '0;
    v.entry_count = CNT_OUT_W'(list_q.size());
    return v;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
    list_req_t req;
    req.op = op;
    req.value = value;
    pending_q.push_back(req);
  endtask

  // runs of filling and draining so both limits of the list are visited
  task automatic add_random_requests(int n);
    bit        fill;
    int        run;
    int        r;
    list_req_t req;
    fill = 1'b0;
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        fill = !fill;
        run = $urandom_range(60, 15);
      end
      run--;
      r = $urandom_range(99);
      if (r < (fill ? 35 : 12)) req.op = OP_PUSH_FRONT;
      else if (r < (fill ? 70 : 24)) req.op = OP_PUSH_BACK;
      else if (r < (fill ? 80 : 52)) req.op = OP_POP_FRONT;
      else if (r < (fill ? 88 : 80)) req.op = OP_POP_BACK;
      else if (r < 97) req.op = OP_DELETE;
      else req.op = OP_W'($urandom_range((1 << OP_W) - 1, int'(OP_DELETE) + 1));
      req.value = ($urandom_range(99) < 70) ? value_pool[$urandom_range(POOL_SIZE-1)]
                                           : VAL_W'($urandom);
      pending_q.push_back(req);
    end
  endtask

  always @(posedge clk) begin
    list_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) view_q.push_back(apply_request(list_req_t'({s_tuser, s_tdata})));
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= req.op;
          s_tdata  <= req.value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    list_view_t seen;
    list_view_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = list_view_t'({m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[68:64]});
        if (view_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result with no request pending: status %0d first %h last %h count %0d",
                     seen.status, seen.first_value, seen.last_value, seen.entry_count);
        end else begin
          want = view_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: status %0d/%0d first %h/%h last %h/%h count %0d/%0d",
                       want.status, seen.status, want.first_value, seen.first_value,
                       want.last_value, seen.last_value, want.entry_count, seen.entry_count);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = VAL_W'($urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list and unused op codes
    add_request(OP_POP_FRONT, 32'h0000_0001);
    add_request(OP_POP_BACK, 32'h0000_0002);
    add_request(OP_DELETE, 32'h0000_0000);
    for (int k = int'(OP_DELETE) + 1; k < (1 << OP_W); k++) add_request(OP_W'(k), VAL_W'($urandom));
    // extremes, duplicates, first match, not found
    add_request(OP_PUSH_FRONT, 32'h8000_0000);
    add_request(OP_PUSH_BACK, 32'h7fff_ffff);
    add_request(OP_PUSH_FRONT, 32'hffff_ffff);
    add_request(OP_PUSH_BACK, 32'h0000_0000);
    add_request(OP_PUSH_BACK, 32'h7fff_ffff);
    add_request(OP_DELETE, 32'h1234_5678);
    add_request(OP_DELETE, 32'h7fff_ffff);
    add_request(OP_DELETE, 32'hffff_ffff);
    add_request(OP_POP_BACK, 32'h0000_0000);
    add_request(OP_POP_FRONT, 32'h0000_0000);
    add_request(OP_POP_FRONT, 32'h0000_0000);
    // removing the last remaining entry from each end and by delete
    add_request(OP_PUSH_BACK, 32'h5555_5555);
    add_request(OP_POP_BACK, 32'h0000_0000);
    add_request(OP_PUSH_FRONT, 32'haaaa_aaaa);
    add_request(OP_DELETE, 32'haaaa_aaaa);
    add_request(OP_PUSH_BACK, 32'h0f0f_0f0f);
    add_request(OP_POP_FRONT, 32'h0000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      add_random_requests(REQS_PER_PHASE);
      while (pending_q.size() != 0 || s_tvalid || view_q.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && view_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/oldq_pkg.sv
sv/oldq_dp.sv
sv/oldq_ctrl.sv
sv/ordered_list_deque_with_delete.sv
verif/ordered_list_deque_with_delete_tb.sv
